@@ rtl/mlp_train_step_macros.svh @@
// Assertion macros shared by the checker files of mlp_train_step.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MLP_TRAIN_STEP_MACROS_SVH
`define MLP_TRAIN_STEP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
// Shared types and constants of the two-layer perceptron trainer.
// No dependencies; used by mts_alu, mts_seq, mlp_train_step and mts_checker.
`default_nettype none

package mts_pkg;

  // Item actions carried in tuser
  localparam logic [2:0] ACT_LOAD_W  = 3'd0;
  localparam logic [2:0] ACT_LOAD_F  = 3'd1;
  localparam logic [2:0] ACT_LOAD_T  = 3'd2;
  localparam logic [2:0] ACT_PREDICT = 3'd3;
  localparam logic [2:0] ACT_TRAIN   = 3'd4;

  localparam int             PRED_W     = 17;
  localparam logic [31:0]    PRED_SCALE = 32'd100000;
  localparam logic [15:0]    LR_RESET   = 16'd6554;
  localparam int             LR_FRAC    = 16;

  // Operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_LR,
    OP_SIG,
    OP_TANH
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

@@ rtl/mts_alu.sv @@
// Shared fixed-point unit: saturating multiply, add, subtract, step scaling,
// and piecewise-linear sigmoid and tanh. Depends on mts_pkg.
`default_nettype none

module mts_alu #(
  parameter int FRAC_BITS = 16
) (
  input  mts_pkg::alu_req_t   req,
  input  logic [15:0]         lr,
  output logic signed [31:0]  y
);

  localparam logic [34:0] ONE35 = 35'(1) << FRAC_BITS;
  localparam logic [34:0] T_SAT = 35'(5) << FRAC_BITS;
  localparam logic [34:0] T_MID = (35'(19) << FRAC_BITS) >> 3;
  localparam logic [34:0] C_HI  = (35'(27) << FRAC_BITS) >> 5;
  localparam logic [34:0] C_MID = (35'(5) << FRAC_BITS) >> 3;
  localparam logic [34:0] C_LO  = ONE35 >> 1;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam int LR_FRAC_SH = mts_pkg::LR_FRAC;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] lrmul(input logic [15:0] l,
                                               input logic signed [31:0] d);
    logic signed [48:0] p;
    logic signed [48:0] s;
    p = $signed({1'b0, l}) * d;
    s = p >>> LR_FRAC_SH;
    return sat32(64'(s));
  endfunction

  function automatic logic signed [31:0] sig(input logic signed [33:0] x);
    logic [34:0] ax;
    logic [34:0] v;
    logic [34:0] r;
    ax = x[33] ? 35'(-x) : 35'(x);
    if (ax >= T_SAT) v = ONE35;
    else if (ax >= T_MID) v = (ax >> 5) + C_HI;
    else if (ax >= ONE35) v = (ax >> 3) + C_MID;
    else v = (ax >> 2) + C_LO;
    r = x[33] ? ONE35 - v : v;
    return $signed(r[31:0]);
  endfunction

  logic signed [31:0] s2;
  logic signed [32:0] sum;
  logic signed [32:0] dif;

  // Evaluate the requested operation
  always_comb begin
    s2  = sig({req.a[31], req.a, 1'b0});
    sum = req.a + req.b;
    dif = req.a - req.b;
    case (req.op)
      mts_pkg::OP_MUL:  y = qmul(req.a, req.b);
      mts_pkg::OP_ADD:  y = sat32(64'(sum));
      mts_pkg::OP_SUB:  y = sat32(64'(dif));
      mts_pkg::OP_LR:   y = lrmul(lr, req.a);
      mts_pkg::OP_SIG:  y = sig({{2{req.a[31]}}, req.a});
      mts_pkg::OP_TANH: y = (s2 <<< 1) - ONE_Q;
      default:          y = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mts_seq.sv @@
// Sequencer and stores of the perceptron: weight memory, feature, target,
// activation and delta registers, driving the shared unit. Uses mts_pkg.
`default_nettype none

module mts_seq #(
  parameter int NUM_IN    = 2,
  parameter int NUM_HID   = 3,
  parameter int NUM_OUT   = 1,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic [7:0]                    in_index,
  input  logic signed [31:0]            in_value,
  input  logic                          out_free,
  output logic                          res_valid,
  output logic [mts_pkg::PRED_W-1:0]    res_pred,
  output mts_pkg::alu_req_t             alu_req,
  input  logic signed [31:0]            alu_y
);

  localparam int B1_BASE   = NUM_IN * NUM_HID;
  localparam int W2_BASE   = B1_BASE + NUM_HID;
  localparam int B2_BASE   = W2_BASE + NUM_HID * NUM_OUT;
  localparam int NUM_WORDS = B2_BASE + NUM_OUT;
  localparam int AW        = $clog2(NUM_WORDS);
  localparam int MAXN      = (NUM_IN > NUM_HID) ?
                             ((NUM_IN > NUM_OUT) ? NUM_IN : NUM_OUT) :
                             ((NUM_HID > NUM_OUT) ? NUM_HID : NUM_OUT);
  localparam int CW        = $clog2(MAXN + 1);
  localparam int IN_IW     = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
  localparam int HID_IW    = (NUM_HID > 1) ? $clog2(NUM_HID) : 1;
  localparam int OUT_IW    = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRE  = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_BRD  = 4'd5;
  localparam logic [3:0] ST_BADD = 4'd6;
  localparam logic [3:0] ST_ACT  = 4'd7;
  localparam logic [3:0] ST_D1   = 4'd8;
  localparam logic [3:0] ST_D2   = 4'd9;
  localparam logic [3:0] ST_D3   = 4'd10;
  localparam logic [3:0] ST_D4   = 4'd11;
  localparam logic [3:0] ST_PRED = 4'd12;

  // Phases of a step
  localparam logic [2:0] PH_FH = 3'd0;  // forward, hidden layer
  localparam logic [2:0] PH_FO = 3'd1;  // forward, output layer
  localparam logic [2:0] PH_OD = 3'd2;  // output deltas
  localparam logic [2:0] PH_HD = 3'd3;  // hidden deltas
  localparam logic [2:0] PH_U1 = 3'd4;  // first-layer update
  localparam logic [2:0] PH_U2 = 3'd5;  // second-layer update

  logic [3:0]        state;
  logic [2:0]        phase;
  logic              train;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;

  logic signed [31:0] mem [NUM_WORDS];
  logic signed [31:0] rdata;
  logic signed [31:0] feat [NUM_IN];
  logic signed [31:0] tgt  [NUM_OUT];
  logic signed [31:0] hid  [NUM_HID];
  logic signed [31:0] hdel [NUM_HID];
  logic signed [31:0] odel [NUM_OUT];
  logic signed [31:0] oact [NUM_OUT];
  logic signed [31:0] acc;
  logic signed [31:0] tmp;
  logic signed [31:0] tmp2;
  logic signed [31:0] st;

  logic [CW-1:0]      n_unit;
  logic [CW-1:0]      n_inner;
  logic               is_upd;
  logic               last_i;
  logic               last_j;
  logic [AW-1:0]      w_addr;
  logic [AW-1:0]      b_addr;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               accept;
  logic               load_w;
  logic signed [31:0] op_a;
  logic signed [31:0] hid_i;
  logic signed [31:0] oact_i;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == ST_PRED) && out_free;
  assign res_pred  = alu_y[mts_pkg::PRED_W-1:0];
  assign is_upd    = (phase == PH_U1) || (phase == PH_U2);
  assign last_i    = (i == n_unit - CW'(1));
  assign last_j    = (j == n_inner - CW'(1));
  assign hid_i     = hid[i[HID_IW-1:0]];
  assign oact_i    = oact[i[OUT_IW-1:0]];
  assign load_w    = accept && (in_action == mts_pkg::ACT_LOAD_W) &&
                     ({1'b0, in_index} < 9'(NUM_WORDS));

  // Loop bounds and addresses of the current phase
  always_comb begin
    n_unit  = CW'(NUM_HID);
    n_inner = CW'(NUM_IN);
    w_addr  = AW'(int'(j) * NUM_HID + int'(i));
    b_addr  = AW'(B1_BASE + int'(i));
    case (phase)
      PH_FO, PH_U2: begin
        n_unit  = CW'(NUM_OUT);
        n_inner = CW'(NUM_HID);
        w_addr  = AW'(W2_BASE + int'(j) * NUM_OUT + int'(i));
        b_addr  = AW'(B2_BASE + int'(i));
      end
      PH_OD: begin
        n_unit  = CW'(NUM_OUT);
        n_inner = CW'(NUM_HID);
      end
      PH_HD: begin
        n_inner = CW'(NUM_OUT);
        w_addr  = AW'(W2_BASE + int'(i) * NUM_OUT + int'(j));
      end
      default: ;
    endcase
  end

  // Vector operand of the inner loop
  always_comb begin
    case (phase)
      PH_FO, PH_U2: op_a = hid[j[HID_IW-1:0]];
      PH_HD:        op_a = odel[j[OUT_IW-1:0]];
      default:      op_a = feat[j[IN_IW-1:0]];
    endcase
  end

  // Request to the shared unit
  always_comb begin
    alu_req.op = mts_pkg::OP_ADD;
    alu_req.a  = acc;
    alu_req.b  = tmp;
    unique case (state)
      ST_PRE: begin
        alu_req.op = mts_pkg::OP_LR;
        alu_req.a  = (phase == PH_U1) ? hdel[i[HID_IW-1:0]] : odel[i[OUT_IW-1:0]];
      end
      ST_MUL: begin
        alu_req.op = mts_pkg::OP_MUL;
        alu_req.a  = is_upd ? st : op_a;
        alu_req.b  = is_upd ? op_a : rdata;
      end
      ST_ACC: begin
        alu_req.a = is_upd ? rdata : acc;
      end
      ST_BADD: begin
        alu_req.a = is_upd ? rdata : acc;
        alu_req.b = is_upd ? st : rdata;
      end
      ST_ACT: begin
        alu_req.op = (phase == PH_FH) ? mts_pkg::OP_TANH : mts_pkg::OP_SIG;
      end
      ST_D1: begin
        alu_req.op = mts_pkg::OP_SUB;
        alu_req.a  = ONE_Q;
        alu_req.b  = (phase == PH_OD) ? oact_i : hid_i;
      end
      ST_D2: begin
        alu_req.op = (phase == PH_OD) ? mts_pkg::OP_MUL : mts_pkg::OP_ADD;
        alu_req.a  = (phase == PH_OD) ? oact_i : ONE_Q;
        alu_req.b  = (phase == PH_OD) ? tmp : hid_i;
      end
      ST_D3: begin
        alu_req.op = (phase == PH_OD) ? mts_pkg::OP_SUB : mts_pkg::OP_MUL;
        alu_req.a  = (phase == PH_OD) ? tgt[i[OUT_IW-1:0]] : tmp;
        alu_req.b  = (phase == PH_OD) ? oact_i : tmp2;
      end
      ST_D4: begin
        alu_req.op = mts_pkg::OP_MUL;
        alu_req.a  = (phase == PH_OD) ? tmp : acc;
        alu_req.b  = (phase == PH_OD) ? tmp2 : tmp;
      end
      ST_PRED: begin
        alu_req.op = mts_pkg::OP_MUL;
        alu_req.a  = oact[0];
        alu_req.b  = $signed(mts_pkg::PRED_SCALE);
      end
      default: ;
    endcase
  end

  // Weight memory ports
  assign raddr = ((state == ST_BRD) || (state == ST_BADD)) ? b_addr : w_addr;
  always_comb begin
    we    = 1'b0;
    waddr = in_index[AW-1:0];
    if (load_w) begin
      we = 1'b1;
    end else if (is_upd && (state == ST_ACC)) begin
      we    = 1'b1;
      waddr = w_addr;
    end else if (is_upd && (state == ST_BADD)) begin
      we    = 1'b1;
      waddr = b_addr;
    end
  end

  function automatic logic signed [31:0] alu_y_or_value(input logic ld);
    return ld ? in_value : alu_y;
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= alu_y_or_value(load_w);
    rdata <= mem[raddr];
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_FH;
      train <= 1'b0;
      i     <= '0;
      j     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && ((in_action == mts_pkg::ACT_PREDICT) ||
                         (in_action == mts_pkg::ACT_TRAIN))) begin
            train <= (in_action == mts_pkg::ACT_TRAIN);
            phase <= PH_FH;
            i     <= '0;
            j     <= '0;
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          j     <= '0;
          state <= (phase == PH_OD) ? ST_D1 : ST_RD;
        end
        ST_RD:  state <= ST_MUL;
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          if (!last_j) begin
            j     <= j + CW'(1);
            state <= ST_RD;
          end else begin
            state <= (phase == PH_HD) ? ST_D1 : ST_BRD;
          end
        end
        ST_BRD: state <= ST_BADD;
        ST_BADD, ST_ACT, ST_D4: begin
          if ((state == ST_BADD) && !is_upd) begin
            state <= ST_ACT;
          end else if (!last_i) begin
            i     <= i + CW'(1);
            state <= ST_PRE;
          end else begin
            i     <= '0;
            state <= ST_PRE;
            case (phase)
              PH_FH: phase <= PH_FO;
              PH_FO: begin
                if (train) phase <= PH_OD;
                else state <= ST_PRED;
              end
              PH_OD: phase <= PH_HD;
              PH_HD: phase <= PH_U1;
              PH_U1: phase <= PH_U2;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_D1: state <= ST_D2;
        ST_D2: state <= ST_D3;
        ST_D3: state <= ST_D4;
        ST_PRED: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture loads and intermediate results
  always_ff @(posedge clk) begin
    if (accept && (in_action == mts_pkg::ACT_LOAD_F) &&
        ({1'b0, in_index} < 9'(NUM_IN)))
      feat[in_index[IN_IW-1:0]] <= in_value;
    if (accept && (in_action == mts_pkg::ACT_LOAD_T) &&
        ({1'b0, in_index} < 9'(NUM_OUT)))
      tgt[in_index[OUT_IW-1:0]] <= in_value;
    case (state)
      ST_PRE: begin
        acc <= '0;
        st  <= alu_y;
      end
      ST_MUL: tmp <= alu_y;
      ST_ACC: if (!is_upd) acc <= alu_y;
      ST_BADD: if (!is_upd) acc <= alu_y;
      ST_ACT: begin
        if (phase == PH_FH) hid[i[HID_IW-1:0]] <= alu_y;
        else oact[i[OUT_IW-1:0]] <= alu_y;
      end
      ST_D1: tmp <= alu_y;
      ST_D2: begin
        if (phase == PH_OD) tmp <= alu_y;
        else tmp2 <= alu_y;
      end
      ST_D3: begin
        if (phase == PH_OD) tmp2 <= alu_y;
        else tmp <= alu_y;
      end
      ST_D4: begin
        if (phase == PH_OD) odel[i[OUT_IW-1:0]] <= alu_y;
        else hdel[i[HID_IW-1:0]] <= alu_y;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mlp_train_step.sv @@
// Top level of the two-layer perceptron trainer: handshakes, step-size
// register, result register. Uses mts_pkg, mts_alu and mts_seq.
//
//   channel   signals                        carries
//   s_axis    tvalid tready tdata tuser      load, predict or train item
//   m_axis    tvalid tready tdata            prediction of a predict item
//   cfg       cfg_valid cfg_ready cfg_data   learning rate, Q0.16
//
// A load item is taken while idle and leaves the input ready. A predict or
// train item holds the input not ready until it is done: every product and
// sum goes one at a time through the shared unit, with a registered weight
// memory read ahead of it. Reset clears control and loads learning rate 6554;
// stores hold garbage until written. A held result stalls only the end of the
// next predict item.
`default_nettype none

module mlp_train_step #(
  parameter int NUM_IN    = 2,
  parameter int NUM_HID   = 3,
  parameter int NUM_OUT   = 1,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // index [7:0], value [39:8]
  input  logic [2:0]  s_axis_tuser,   // action [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // prediction [16:0], zero [23:17]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]                     lr;
  logic                            out_valid;
  logic [mts_pkg::PRED_W-1:0]      out_data;
  logic                            out_free;
  logic                            res_valid;
  logic [mts_pkg::PRED_W-1:0]      res_pred;
  mts_pkg::alu_req_t               alu_req;
  logic signed [31:0]              alu_y;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(24 - mts_pkg::PRED_W)'(0), out_data};

  // Hold the step size
  always_ff @(posedge clk) begin
    if (rst) lr <= mts_pkg::LR_RESET;
    else if (cfg_valid && cfg_ready) lr <= cfg_data;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data <= res_pred;
  end

  mts_seq #(
    .NUM_IN    (NUM_IN),
    .NUM_HID   (NUM_HID),
    .NUM_OUT   (NUM_OUT),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_index  (s_axis_tdata[7:0]),
    .in_value  ($signed(s_axis_tdata[39:8])),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_pred  (res_pred),
    .alu_req   (alu_req),
    .alu_y     (alu_y)
  );

  mts_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .req (alu_req),
    .lr  (lr),
    .y   (alu_y)
  );

endmodule

`default_nettype wire

@@ rtl/mts_checker.sv @@
// Port-level checks of mlp_train_step, bound to the top level.
// Uses the assertion macros of mlp_train_step_macros.svh.
`default_nettype none

`include "mlp_train_step_macros.svh"

module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic step_item;
  logic load_item;

  assign step_item = s_axis_tvalid && s_axis_tready &&
                     ((s_axis_tuser == mts_pkg::ACT_PREDICT) ||
                      (s_axis_tuser == mts_pkg::ACT_TRAIN));
  assign load_item = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == mts_pkg::ACT_LOAD_W);

  `MTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `MTS_ASSERT_NOW(a_pred_range, m_axis_tvalid, (m_axis_tdata[16:0] <= 17'd100000) && (m_axis_tdata[23:17] == 7'd0), "prediction out of range")
  `MTS_ASSERT_NEXT(a_step_busy, step_item, !s_axis_tready, "ready right after a step item")
  `MTS_ASSERT_NEXT(a_load_fast, load_item, s_axis_tready, "not ready after a load item")

endmodule

bind mlp_train_step mts_checker u_mts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
